// ----- sv/kvrp_pkg.sv -----
`timescale 1ns / 1ps

package kvrp_pkg;

    // result slots one item can fill
    localparam int SLOTS  = 4;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // group queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    typedef enum logic [2:0] {
        K_KEY  = 3'd0,
        K_VAL  = 3'd1,
        K_PAIR = 3'd2,
        K_BARE = 3'd3,
        K_OK   = 3'd4,
        K_ERR  = 3'd5
    } kind_t;

    typedef enum logic [5:0] {
        PH_KEY_START   = 6'b000001,
        PH_KEY         = 6'b000010,
        PH_VAL_START   = 6'b000100,
        PH_UNQUOTED    = 6'b001000,
        PH_QUOTED      = 6'b010000,
        PH_AFTER_QUOTE = 6'b100000
    } phase_t;

    // all results caused by one item
    typedef struct packed {
        logic [CNT_W-1:0]            count;
        kind_t [SLOTS-1:0]           kinds;
        logic [SLOTS-1:0][7:0]       bytes;
    } group_t;

endpackage

// ----- sv/kvrp_front.sv -----
`timescale 1ns / 1ps

module kvrp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      line_byte,
    input  logic            line_end,
    input  logic            end_only,
    input  logic            q_full,
    output logic            push,
    output kvrp_pkg::group_t grp
);
    import kvrp_pkg::*;

    phase_t     phase_reg, phase_next;
    logic       esc_reg, esc_next;
    logic [1:0] od_reg, od_next;
    logic [7:0] oa_reg, oa_next;
    logic       ofh_reg, ofh_next;
    logic       do_key;
    logic       skip;
    logic       is_oct;
    logic [1:0] limit;
    logic       accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (grp.count != '0);
    assign is_oct   = (line_byte >= CH_0) && (line_byte <= CH_7);
    assign limit    = ofh_reg ? 2'd2 : 2'd3;

    always_comb
    begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        od_next    = od_reg;
        oa_next    = oa_reg;
        ofh_next   = ofh_reg;
        grp        = '0;
        do_key     = 1'b0;
        skip       = 1'b0;
        if (!end_only)
        begin
            unique case (phase_reg)
                PH_VAL_START:
                begin
                    if (line_byte == CH_QUOTE)
                    begin
                        phase_next = PH_QUOTED;
                    end
                    else if (line_byte == CH_SPACE)
                    begin
                        grp.kinds[grp.count[SLOT_W-1:0]] = K_PAIR;
                        grp.count = grp.count + 1'b1;
                        phase_next = PH_KEY_START;
                    end
                    else
                    begin
                        grp.kinds[grp.count[SLOT_W-1:0]] = K_VAL;
                        grp.bytes[grp.count[SLOT_W-1:0]] = line_byte;
                        grp.count = grp.count + 1'b1;
                        phase_next = PH_UNQUOTED;
                    end
                end
                PH_UNQUOTED:
                begin
                    if (line_byte == CH_SPACE)
                    begin
                        grp.kinds[grp.count[SLOT_W-1:0]] = K_PAIR;
                        grp.count = grp.count + 1'b1;
                        phase_next = PH_KEY_START;
                    end
                    else
                    begin
                        grp.kinds[grp.count[SLOT_W-1:0]] = K_VAL;
                        grp.bytes[grp.count[SLOT_W-1:0]] = line_byte;
                        grp.count = grp.count + 1'b1;
                    end
                end
                PH_QUOTED:
                begin
                    if (od_reg != 2'd0)
                    begin
                        if (is_oct && (od_reg < limit))
                        begin
                            oa_next = {oa_reg[4:0], line_byte[2:0]};
                            od_next = od_reg + 2'd1;
                            skip    = 1'b1;
                            if (od_next >= limit)
                            begin
                                grp.kinds[grp.count[SLOT_W-1:0]] = K_VAL;
                                grp.bytes[grp.count[SLOT_W-1:0]] = oa_next;
                                grp.count = grp.count + 1'b1;
                                od_next  = 2'd0;
                                oa_next  = 8'd0;
                                ofh_next = 1'b0;
                            end
                        end
                        else
                        begin
                            // non-octal byte flushes the pending octal value first
                            grp.kinds[grp.count[SLOT_W-1:0]] = K_VAL;
                            grp.bytes[grp.count[SLOT_W-1:0]] = oa_reg;
                            grp.count = grp.count + 1'b1;
                            od_next  = 2'd0;
                            oa_next  = 8'd0;
                            ofh_next = 1'b0;
                        end
                    end
                    if (!skip)
                    begin
                        if (esc_reg)
                        begin
                            esc_next = 1'b0;
                            if (is_oct)
                            begin
                                oa_next  = {5'd0, line_byte[2:0]};
                                od_next  = 2'd1;
                                ofh_next = (line_byte > CH_3);
                            end
                            else
                            begin
                                grp.kinds[grp.count[SLOT_W-1:0]] = K_VAL;
                                if (line_byte == CH_N)
                                    grp.bytes[grp.count[SLOT_W-1:0]] = CH_LF;
                                else if (line_byte == CH_T)
                                    grp.bytes[grp.count[SLOT_W-1:0]] = CH_TAB;
                                else if (line_byte == CH_R)
                                    grp.bytes[grp.count[SLOT_W-1:0]] = CH_CR;
                                else
                                    grp.bytes[grp.count[SLOT_W-1:0]] = line_byte;
                                grp.count = grp.count + 1'b1;
                            end
                        end
                        else if (line_byte == CH_BSL)
                        begin
                            esc_next = 1'b1;
                        end
                        else if (line_byte == CH_QUOTE)
                        begin
                            grp.kinds[grp.count[SLOT_W-1:0]] = K_PAIR;
                            grp.count = grp.count + 1'b1;
                            phase_next = PH_AFTER_QUOTE;
                        end
                        else
                        begin
                            grp.kinds[grp.count[SLOT_W-1:0]] = K_VAL;
                            grp.bytes[grp.count[SLOT_W-1:0]] = line_byte;
                            grp.count = grp.count + 1'b1;
                        end
                    end
                end
                PH_AFTER_QUOTE:
                begin
                    if (line_byte == CH_SPACE)
                        phase_next = PH_KEY_START;
                    else
                        do_key = 1'b1;
                end
                default:
                begin
                    do_key = 1'b1;
                end
            endcase
            if (do_key)
            begin
                if (line_byte == CH_EQ)
                begin
                    phase_next = PH_VAL_START;
                end
                else if (line_byte == CH_SPACE)
                begin
                    grp.kinds[grp.count[SLOT_W-1:0]] = K_BARE;
                    grp.count = grp.count + 1'b1;
                    phase_next = PH_KEY_START;
                end
                else
                begin
                    grp.kinds[grp.count[SLOT_W-1:0]] = K_KEY;
                    grp.bytes[grp.count[SLOT_W-1:0]] = line_byte;
                    grp.count = grp.count + 1'b1;
                    phase_next = PH_KEY;
                end
            end
        end
        if (end_only || line_end)
        begin
            unique case (phase_next)
                PH_KEY, PH_QUOTED:
                begin
                    grp.kinds[grp.count[SLOT_W-1:0]] = K_ERR;
                    grp.count = grp.count + 1'b1;
                end
                PH_VAL_START, PH_UNQUOTED:
                begin
                    grp.kinds[grp.count[SLOT_W-1:0]] = K_PAIR;
                    grp.count = grp.count + 1'b1;
                    grp.kinds[grp.count[SLOT_W-1:0]] = K_OK;
                    grp.count = grp.count + 1'b1;
                end
                default:
                begin
                    grp.kinds[grp.count[SLOT_W-1:0]] = K_OK;
                    grp.count = grp.count + 1'b1;
                end
            endcase
            phase_next = PH_KEY_START;
            esc_next   = 1'b0;
            od_next    = 2'd0;
            oa_next    = 8'd0;
            ofh_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_KEY_START;
            esc_reg   <= 1'b0;
            od_reg    <= 2'd0;
            oa_reg    <= 8'd0;
            ofh_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            od_reg    <= od_next;
            oa_reg    <= oa_next;
            ofh_reg   <= ofh_next;
        end
    end

endmodule

// ----- sv/kvrp_queue.sv -----
`timescale 1ns / 1ps

module kvrp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  kvrp_pkg::group_t push_grp,
    input  logic             pop,
    output kvrp_pkg::group_t pop_grp,
    output logic             full,
    output logic             empty
);
    import kvrp_pkg::*;

    group_t              slots_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_grp = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ----- sv/kvrp_back.sv -----
`timescale 1ns / 1ps

module kvrp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  kvrp_pkg::group_t q_grp,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       out_kind,
    output logic [7:0]       out_byte,
    output logic             out_last
);
    import kvrp_pkg::*;

    group_t            grp_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic              busy_reg;
    logic              done;

    assign out_valid = busy_reg;
    assign out_kind  = grp_reg.kinds[idx_reg];
    assign out_byte  = grp_reg.bytes[idx_reg];
    assign out_last  = ({1'b0, idx_reg} == CNT_W'(grp_reg.count - 1'b1));
    assign done      = busy_reg && out_ready && out_last;
    assign pop       = (!busy_reg || done) && !q_empty;

    always_ff @(posedge clk)
    begin
        if (pop)
            grp_reg <= q_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg && out_ready)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

endmodule

// ----- sv/keyvalue_reply_line_parser_core.sv -----
`timescale 1ns / 1ps

// channel  dir  tdata              tuser          tlast
// s_*      in   line_byte [7:0]    end_only [0]   line_end
// m_*      out  out_byte [7:0]     out_kind [2:0] out_last
//
// the front parses one byte per cycle while s_tready is high and writes all
// results of that item as one group into a four-entry queue; the back sends
// one result per cycle while m_tready is high
// with both idle a group passes the queue slot, then the back's group register
// s_tready drops only while the group queue is full
// rst_n is asynchronous; after reset the parser waits at the start of a key
// m_tvalid holds with its result until m_tready takes it

module keyvalue_reply_line_parser_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // line_byte
    input  logic       s_tlast,
    input  logic       s_tuser,    // end_only
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // out_byte
    output logic [2:0] m_tuser,    // out_kind
    output logic       m_tlast
);
    import kvrp_pkg::*;

    group_t push_grp;
    group_t pop_grp;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;

    // byte parser and result grouping
    kvrp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .line_byte (s_tdata),
        .line_end  (s_tlast),
        .end_only  (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .grp       (push_grp)
    );

    // groups waiting for the output side
    kvrp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_grp (push_grp),
        .pop      (pop),
        .pop_grp  (pop_grp),
        .full     (q_full),
        .empty    (q_empty)
    );

    // serializes one group into single results
    kvrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_grp     (pop_grp),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

`ifndef SYNTHESIS
    // a group is never written into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("group pushed into full queue");

    // a line status result always closes its item
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == K_OK || m_tuser == K_ERR) |-> m_tlast)
        else $error("line status not last result of item");

    // marker results carry a zero byte
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != K_KEY && m_tuser != K_VAL |-> m_tdata == 8'd0)
        else $error("marker result with nonzero byte");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import kvrp_pkg::*;

    localparam int RAND_ITEMS   = 120;
    localparam int QUIET_ITEMS  = 30;    // last stretch runs without idling
    localparam int HOLD_CYCLES  = 60;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 20;
    localparam int NROWS        = 27;

    // one result of the parser
    typedef struct {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    // one raw line item
    typedef struct {
        logic [7:0] b;
        logic       le;
        logic       eo;
    } line_item_t;

    // directed row: n_typed > 0 means the results are written out by hand
    typedef struct {
        logic [7:0] b;
        logic       le;
        logic       eo;
        int         n_typed;
        kind_t      k0;
        logic [7:0] d0;
        kind_t      k1;
        logic [7:0] d1;
    } row_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // line_byte
    logic       s_tlast;    // line_end
    logic       s_tuser;    // end_only
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // out_byte
    logic [2:0] m_tuser;    // out_kind
    logic       m_tlast;    // out_last

    // parser state mirrored from the block's behavior
    phase_t     line_phase;
    logic       esc_seen;
    logic [1:0] oct_cnt;
    logic [7:0] oct_val;
    logic       oct_high;

    result_t    item_results[$];
    result_t    parsed_results[$];
    line_item_t line_items[$];

    int         errors = 0;
    logic       quiet = 1'b0;
    logic       hold_off = 1'b0;

    keyvalue_reply_line_parser_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #1ms;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // parser prediction

    function automatic void clear_parser();
        line_phase = PH_KEY_START;
        esc_seen   = 1'b0;
        oct_cnt    = 2'd0;
        oct_val    = 8'h00;
        oct_high   = 1'b0;
    endfunction

    function automatic void add_result(input kind_t k, input logic [7:0] d);
        result_t r;
        r = '{kind: k, data: d, last: 1'b0};
        item_results = {item_results, r};
    endfunction

    function automatic void key_char(input logic [7:0] b);
        if (b == CH_EQ)
            line_phase = PH_VAL_START;
        else if (b == CH_SPACE)
        begin
            add_result(K_BARE, 8'h00);
            line_phase = PH_KEY_START;
        end
        else
        begin
            add_result(K_KEY, b);
            line_phase = PH_KEY;
        end
    endfunction

    function automatic void quoted_char(input logic [7:0] b);
        logic [1:0] lim;
        logic       is_oct;
        lim    = oct_high ? 2'd2 : 2'd3;
        is_oct = (b >= CH_0) && (b <= CH_7);
        if (oct_cnt != 2'd0)
        begin
            if (is_oct && oct_cnt < lim)
            begin
                oct_val = {oct_val[4:0], b[2:0]};
                oct_cnt = oct_cnt + 2'd1;
                if (oct_cnt >= lim)
                begin
                    add_result(K_VAL, oct_val);
                    oct_cnt  = 2'd0;
                    oct_val  = 8'h00;
                    oct_high = 1'b0;
                end
                return;
            end
            // octal run cut short by a non-octal byte
            add_result(K_VAL, oct_val);
            oct_cnt  = 2'd0;
            oct_val  = 8'h00;
            oct_high = 1'b0;
        end
        if (esc_seen)
        begin
            esc_seen = 1'b0;
            if (b == CH_N)
                add_result(K_VAL, CH_LF);
            else if (b == CH_T)
                add_result(K_VAL, CH_TAB);
            else if (b == CH_R)
                add_result(K_VAL, CH_CR);
            else if (is_oct)
            begin
                oct_val  = {5'd0, b[2:0]};
                oct_cnt  = 2'd1;
                oct_high = (b > CH_3);
            end
            else
                add_result(K_VAL, b);
            return;
        end
        if (b == CH_BSL)
            esc_seen = 1'b1;
        else if (b == CH_QUOTE)
        begin
            add_result(K_PAIR, 8'h00);
            line_phase = PH_AFTER_QUOTE;
        end
        else
            add_result(K_VAL, b);
    endfunction

    // all results one item causes, in item_results
    function automatic void parse_item(input logic [7:0] b, input logic le, input logic eo);
        item_results.delete();
        if (!eo)
        begin
            case (line_phase)
                PH_VAL_START:
                    if (b == CH_QUOTE)
                        line_phase = PH_QUOTED;
                    else if (b == CH_SPACE)
                    begin
                        add_result(K_PAIR, 8'h00);
                        line_phase = PH_KEY_START;
                    end
                    else
                    begin
                        add_result(K_VAL, b);
                        line_phase = PH_UNQUOTED;
                    end
                PH_UNQUOTED:
                    if (b == CH_SPACE)
                    begin
                        add_result(K_PAIR, 8'h00);
                        line_phase = PH_KEY_START;
                    end
                    else
                        add_result(K_VAL, b);
                PH_QUOTED:
                    quoted_char(b);
                PH_AFTER_QUOTE:
                    if (b == CH_SPACE)
                        line_phase = PH_KEY_START;
                    else
                        key_char(b);
                default:
                    key_char(b);
            endcase
        end
        if (eo || le)
        begin
            case (line_phase)
                PH_KEY, PH_QUOTED:
                    add_result(K_ERR, 8'h00);
                PH_VAL_START, PH_UNQUOTED:
                begin
                    add_result(K_PAIR, 8'h00);
                    add_result(K_OK, 8'h00);
                end
                default:
                    add_result(K_OK, 8'h00);
            endcase
            clear_parser();
        end
        if (item_results.size() > 0)
            item_results[item_results.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // random line building

    function automatic void push_item(input logic [7:0] b, input logic le, input logic eo);
        line_item_t li;
        li = '{b: b, le: le, eo: eo};
        line_items = {line_items, li};
    endfunction

    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0: return CH_EQ;
            1: return CH_QUOTE;
            2: return CH_BSL;
            3: return CH_SPACE;
            4: return CH_0;
            5: return CH_7;
            6: return CH_N;
            default: return 8'($urandom_range(CH_0, CH_7));
        endcase
    endfunction

    function automatic void quoted_value();
        logic [7:0] c;
        repeat ($urandom_range(0, 5))
        begin
            case ($urandom_range(0, 5))
                0, 1:
                begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CH_BSL || c == CH_QUOTE)
                        c = 8'h61;
                    push_item(c, 1'b0, 1'b0);
                end
                2:
                begin
                    push_item(CH_BSL, 1'b0, 1'b0);
                    case ($urandom_range(0, 2))
                        0: push_item(CH_N, 1'b0, 1'b0);
                        1: push_item(CH_T, 1'b0, 1'b0);
                        default: push_item(CH_R, 1'b0, 1'b0);
                    endcase
                end
                3:
                begin
                    // octal run, sometimes longer than its digit limit
                    push_item(CH_BSL, 1'b0, 1'b0);
                    push_item(8'($urandom_range(CH_0, CH_7)), 1'b0, 1'b0);
                    repeat ($urandom_range(0, 3))
                        push_item(8'($urandom_range(CH_0, CH_7)), 1'b0, 1'b0);
                end
                4:
                begin
                    push_item(CH_BSL, 1'b0, 1'b0);
                    push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
                default:
                begin
                    push_item(CH_BSL, 1'b0, 1'b0);
                    push_item($urandom_range(0, 1) ? CH_QUOTE : CH_BSL, 1'b0, 1'b0);
                end
            endcase
        end
        // now and then the closing quote is missing
        if ($urandom_range(0, 7) != 0)
            push_item(CH_QUOTE, 1'b0, 1'b0);
    endfunction

    function automatic void build_line();
        int         ntok;
        int         form;
        logic [7:0] c;
        if ($urandom_range(0, 4) == 0)
        begin
            // noise line
            repeat ($urandom_range(1, 8))
                push_item(noise_byte(), $urandom_range(0, 7) == 0,
                          $urandom_range(0, 15) == 0);
            line_items[line_items.size()-1].le = 1'b1;
            return;
        end
        ntok = $urandom_range(1, 4);
        for (int t = 0; t < ntok; t++)
        begin
            repeat ($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 3))
            begin
                if ($urandom_range(0, 7) == 0)
                    c = 8'($urandom_range(0, 255));
                else
                    c = 8'($urandom_range(8'h21, 8'h7e));
                if (c == CH_EQ || c == CH_SPACE)
                    c = 8'h6b;
                push_item(c, 1'b0, 1'b0);
            end
            form = $urandom_range(0, 3);
            if (form == 0)
                push_item(CH_SPACE, 1'b0, 1'b0);
            else
            begin
                push_item(CH_EQ, 1'b0, 1'b0);
                if (form == 1)
                    repeat ($urandom_range(1, 4))
                    begin
                        c = 8'($urandom_range(0, 255));
                        if (c == CH_SPACE)
                            c = 8'h5f;
                        push_item(c, 1'b0, 1'b0);
                    end
                else if (form == 2)
                begin
                    push_item(CH_QUOTE, 1'b0, 1'b0);
                    quoted_value();
                end
                if (t < ntok - 1 && (form != 2 || $urandom_range(0, 1) == 0))
                    push_item(CH_SPACE, 1'b0, 1'b0);
            end
        end
        if ($urandom_range(0, 3) == 0)
            push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        else
            line_items[line_items.size()-1].le = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // sender

    task automatic offer_item(input logic [7:0] b, input logic le, input logic eo);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= le;
        s_tuser  <= eo;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        row_t       dir_rows [NROWS];
        line_item_t it;
        result_t    typed;
        int         sent;

        dir_rows = '{
            // empty line: end only, byte and line_end ignored
            '{8'hff, 1'b0, 1'b1, 1, K_OK,  8'h00, K_KEY, 8'h00},
            // line ends inside a key
            '{8'h00, 1'b1, 1'b0, 2, K_KEY, 8'h00, K_ERR, 8'h00},
            '{8'hff, 1'b0, 1'b0, 1, K_KEY, 8'hff, K_KEY, 8'h00},
            '{CH_EQ,    1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            '{8'h76,    1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            '{CH_SPACE, 1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            // bare keyword with an empty key
            '{CH_SPACE, 1'b0, 1'b0, 1, K_BARE, 8'h00, K_KEY, 8'h00},
            // empty key, quoted value with escapes
            '{CH_EQ,    1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            '{CH_QUOTE, 1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            '{CH_BSL,   1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            '{CH_T,     1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            '{CH_BSL,   1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            '{8'h31,    1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            '{8'h30,    1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            '{8'h31,    1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            // high first digit: two-digit limit
            '{CH_BSL,   1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            '{8'h36,    1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            '{8'h33,    1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            // octal cut short by the closing quote
            '{CH_BSL,   1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            '{8'h32,    1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            '{CH_QUOTE, 1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            // byte after the quote starts a key that ends with the line
            '{8'h7a,    1'b1, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            '{8'h61,    1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            '{CH_EQ,    1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            '{CH_QUOTE, 1'b0, 1'b0, 0, K_KEY, 8'h00, K_KEY, 8'h00},
            // line ends with an escape pending
            '{CH_BSL,   1'b1, 1'b0, 1, K_ERR, 8'h00, K_KEY, 8'h00},
            // empty key and empty value at the line end
            '{CH_EQ,    1'b1, 1'b0, 2, K_PAIR, 8'h00, K_OK, 8'h00}
        };

        rst_n = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        s_tuser  <= 1'b0;
        clear_parser();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            parse_item(dir_rows[i].b, dir_rows[i].le, dir_rows[i].eo);
            if (dir_rows[i].n_typed > 0)
            begin
                item_results.delete();
                typed = '{kind: dir_rows[i].k0, data: dir_rows[i].d0,
                          last: dir_rows[i].n_typed == 1};
                item_results = {item_results, typed};
                if (dir_rows[i].n_typed == 2)
                begin
                    typed = '{kind: dir_rows[i].k1, data: dir_rows[i].d1, last: 1'b1};
                    item_results = {item_results, typed};
                end
            end
            foreach (item_results[j])
                parsed_results = {parsed_results, item_results[j]};
            offer_item(dir_rows[i].b, dir_rows[i].le, dir_rows[i].eo);
        end

        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            build_line();
            while (line_items.size() > 0)
            begin
                it = line_items[0];
                line_items.delete(0);
                if (sent == 10)
                    hold_off = 1'b1;
                quiet = (sent >= RAND_ITEMS - QUIET_ITEMS);
                parse_item(it.b, it.le, it.eo);
                foreach (item_results[j])
                    parsed_results = {parsed_results, item_results[j]};
                offer_item(it.b, it.le, it.eo);
                sent++;
            end
        end

        s_tvalid <= 1'b0;
        while (parsed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: short random stalls, one long hold-off, calm at the end

    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // result check against the oldest waiting result

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (parsed_results.size() == 0)
            begin
                $error("unexpected item: out_kind %0d out_byte %h out_last %b",
                       m_tuser, m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                want = parsed_results[0];
                parsed_results.delete(0);
                if (m_tuser !== want.kind)
                begin
                    $error("out_kind: expected %0d, actual %0d", want.kind, m_tuser);
                    errors++;
                end
                if (m_tdata !== want.data)
                begin
                    $error("out_byte: expected %h, actual %h", want.data, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("out_last: expected %b, actual %b", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

endmodule
